>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the voxel sampler checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, aborted while reset is high
`define VGTS_ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vgts check failed");

// clocked assertion, also checked during reset
`define VGTS_ASSERT(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("vgts check failed");

`endif

>>> src/vgts_pkg.sv
// ----------------------------------------------------------------------------
// vgts_pkg
// constants, widths and helpers for the trilinear voxel sampler
// ----------------------------------------------------------------------------
package vgts_pkg;

  localparam int MAX_EDGE = 32;
  localparam int CHANNEL_BITS = 16;
  localparam int IDX_W = $clog2(MAX_EDGE);
  localparam int HALF_W = IDX_W - 1;
  localparam int BANK_DEPTH = (MAX_EDGE / 2) * (MAX_EDGE / 2) * (MAX_EDGE / 2);
  localparam int BANK_AW = $clog2(BANK_DEPTH);
  localparam int NUM_BANKS = 8;
  localparam int VOXEL_W = 3 * CHANNEL_BITS;
  localparam int SIZE_W = 6;
  localparam int COORD_W = 18;
  localparam int FRAC_W = 16;
  localparam int CLAMP_W = FRAC_W + 1;
  localparam int PROD_W = CLAMP_W + SIZE_W;
  localparam int CFG_IDX_W = 2;
  localparam int PIPE_LAT = 9;

  localparam logic [CLAMP_W-1:0] FRAC_ONE = CLAMP_W'(1) << FRAC_W;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_EDGE);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_t;

  typedef logic signed [CHANNEL_BITS-1:0] chan_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_EDGE)) begin
      r = SIZE_W'(MAX_EDGE);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

>>> src/vgts_ram.sv
// ----------------------------------------------------------------------------
// vgts_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module vgts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/vgts_axis.sv
// ----------------------------------------------------------------------------
// vgts_axis
// maps one normalized coordinate to two clamped neighbor indices and a
// 16-bit fraction over two register stages
// ----------------------------------------------------------------------------
module vgts_axis (
  input  logic                                 clk,
  input  logic signed [vgts_pkg::COORD_W-1:0]  coord,
  input  logic [vgts_pkg::SIZE_W-1:0]          size,
  output logic [vgts_pkg::IDX_W-1:0]           idx0,
  output logic [vgts_pkg::IDX_W-1:0]           idx1,
  output logic [vgts_pkg::FRAC_W-1:0]          frac
);
  import vgts_pkg::*;

  logic [CLAMP_W-1:0] clamped;
  logic [SIZE_W-1:0]  n_eff;
  logic [PROD_W-1:0]  prod;
  logic [SIZE_W-1:0]  n_s1;
  logic [PROD_W-1:0]  q;
  logic [SIZE_W-1:0]  k;
  logic [SIZE_W-1:0]  lim;

  always_comb begin
    if (coord < 0) begin
      clamped = '0;
    end else if (coord > $signed({1'b0, FRAC_ONE})) begin
      clamped = FRAC_ONE;
    end else begin
      clamped = coord[CLAMP_W-1:0];
    end
    n_eff = eff_size(size);
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(clamped) * PROD_W'(n_eff);
    n_s1 <= n_eff;
  end

  always_comb begin
    q   = prod + HALF;
    k   = q[FRAC_W +: SIZE_W];
    lim = n_s1 - SIZE_W'(1);
  end

  always_ff @(posedge clk) begin
    idx0 <= (k == '0) ? '0 : IDX_W'(k - SIZE_W'(1));
    idx1 <= (k > lim) ? IDX_W'(lim) : IDX_W'(k);
    frac <= q[FRAC_W-1:0];
  end

endmodule

>>> src/vgts_blend.sv
// ----------------------------------------------------------------------------
// vgts_blend
// trilinear blend of one channel: x, y and z lerps, each split into a
// multiply stage and an add stage
// ----------------------------------------------------------------------------
module vgts_blend (
  input  logic                        clk,
  input  vgts_pkg::chan_t             corner [8],
  input  logic [vgts_pkg::FRAC_W-1:0] fx,
  input  logic [vgts_pkg::FRAC_W-1:0] fy,
  input  logic [vgts_pkg::FRAC_W-1:0] fz,
  output vgts_pkg::chan_t             result
);
  import vgts_pkg::*;

  localparam int DIFF_W = CHANNEL_BITS + 1;
  localparam int MUL_W = DIFF_W + FRAC_W + 1;
  localparam int SH_W = MUL_W - FRAC_W;

  typedef logic signed [MUL_W-1:0] mul_t;

  function automatic mul_t lerp_mul(input chan_t a, input chan_t b,
                                    input logic [FRAC_W-1:0] f);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(b) - DIFF_W'(a);
    return MUL_W'(d) * $signed({{(MUL_W-FRAC_W){1'b0}}, f});
  endfunction

  function automatic chan_t lerp_add(input chan_t a, input mul_t p);
    logic signed [SH_W-1:0] s;
    s = SH_W'(a) + p[MUL_W-1:FRAC_W];
    return s[CHANNEL_BITS-1:0];
  endfunction

  mul_t  px [4];
  chan_t ax0 [4];
  chan_t xr [4];
  mul_t  py [2];
  chan_t ay0 [2];
  chan_t yr [2];
  mul_t  pz;
  chan_t az0;
  logic [FRAC_W-1:0] fy_d [2];
  logic [FRAC_W-1:0] fz_d [4];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      px[j]  <= lerp_mul(corner[2*j], corner[2*j+1], fx);
      ax0[j] <= corner[2*j];
      xr[j]  <= lerp_add(ax0[j], px[j]);
    end
    for (int j = 0; j < 2; j++) begin
      py[j]  <= lerp_mul(xr[2*j], xr[2*j+1], fy_d[1]);
      ay0[j] <= xr[2*j];
      yr[j]  <= lerp_add(ay0[j], py[j]);
    end
    pz     <= lerp_mul(yr[0], yr[1], fz_d[3]);
    az0    <= yr[0];
    result <= lerp_add(az0, pz);
    fy_d[0] <= fy;
    fy_d[1] <= fy_d[0];
    fz_d[0] <= fz;
    for (int j = 1; j < 4; j++) begin
      fz_d[j] <= fz_d[j-1];
    end
  end

endmodule

>>> src/voxel_grid_trilinear_sampler.sv
// sample path: axis mapping, bank read and blend lerps in order, valid delayed to match
// throughput: one item per cycle, write or sample, set by the eight ram banks
// (one per parity of x, y and z) each doing one read and one write a cycle
// reset: clears the valid pipeline and sets all sizes to 32; busy is high
// only during reset, and the receiver cannot stall results
// ----------------------------------------------------------------------------
// voxel_grid_trilinear_sampler
// banked 3-d voxel store with a pipelined clamp-to-edge trilinear filter
// ----------------------------------------------------------------------------
module voxel_grid_trilinear_sampler (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  operation,
  input  logic [4:0]                            voxel_x,
  input  logic [4:0]                            voxel_y,
  input  logic [4:0]                            voxel_z,
  input  logic signed [15:0]                    value_a,
  input  logic signed [15:0]                    value_b,
  input  logic signed [15:0]                    value_c,
  input  logic signed [vgts_pkg::COORD_W-1:0]   coord_u,
  input  logic signed [vgts_pkg::COORD_W-1:0]   coord_v,
  input  logic signed [vgts_pkg::COORD_W-1:0]   coord_w,
  input  logic                                  cfg_we,
  input  logic [vgts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vgts_pkg::SIZE_W-1:0]           cfg_data,
  output logic                                  valid,
  output logic signed [15:0]                    sample_a,
  output logic signed [15:0]                    sample_b,
  output logic signed [15:0]                    sample_c
);
  import vgts_pkg::*;

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic accept;
  logic [1:0] wr_vld;
  logic [VOXEL_W-1:0] wr_data [2];
  logic [IDX_W-1:0] wx [2], wy [2], wz [2];
  logic [PIPE_LAT-1:0] smp_vld;
  logic [IDX_W-1:0] ix0, ix1, iy0, iy1, iz0, iz1;
  logic [FRAC_W-1:0] fx, fy, fz, fx_r, fy_r, fz_r;
  logic px0, px1, py0, py1, pz0, pz1;
  logic [BANK_AW-1:0] raddr [NUM_BANKS];
  logic [VOXEL_W-1:0] rdata [NUM_BANKS];
  logic [NUM_BANKS-1:0] bank_we;
  logic [BANK_AW-1:0] waddr;
  chan_t corner [3][8];
  chan_t res [3];

  assign busy = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_vld  <= '0;
      smp_vld <= '0;
    end else begin
      wr_vld  <= {wr_vld[0], accept && (op_t'(operation) == OP_WRITE)};
      smp_vld <= {smp_vld[PIPE_LAT-2:0], accept && (op_t'(operation) == OP_SAMPLE)};
    end
  end

  always_ff @(posedge clk) begin
    wr_data[0] <= {value_c, value_b, value_a};
    wr_data[1] <= wr_data[0];
    wx[0] <= voxel_x;
    wy[0] <= voxel_y;
    wz[0] <= voxel_z;
    wx[1] <= wx[0];
    wy[1] <= wy[0];
    wz[1] <= wz[0];
  end

  vgts_axis u_axis_x (.clk, .coord(coord_u), .size(size_x), .idx0(ix0), .idx1(ix1), .frac(fx));
  vgts_axis u_axis_y (.clk, .coord(coord_v), .size(size_y), .idx0(iy0), .idx1(iy1), .frac(fy));
  vgts_axis u_axis_z (.clk, .coord(coord_w), .size(size_z), .idx0(iz0), .idx1(iz1), .frac(fz));

  // each bank is read at whichever neighbor index has its parity
  always_comb begin
    logic [IDX_W-1:0] sx, sy, sz;
    waddr = {wz[1][IDX_W-1:1], wy[1][IDX_W-1:1], wx[1][IDX_W-1:1]};
    for (int b = 0; b < NUM_BANKS; b++) begin
      sx = (ix0[0] == b[0]) ? ix0 : ix1;
      sy = (iy0[0] == b[1]) ? iy0 : iy1;
      sz = (iz0[0] == b[2]) ? iz0 : iz1;
      raddr[b] = {sz[IDX_W-1:1], sy[IDX_W-1:1], sx[IDX_W-1:1]};
      bank_we[b] = wr_vld[1] && ({wz[1][0], wy[1][0], wx[1][0]} == 3'(b));
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    vgts_ram #(.WIDTH(VOXEL_W), .DEPTH(BANK_DEPTH)) u_ram (
      .clk,
      .we(bank_we[b]),
      .waddr,
      .wdata(wr_data[1]),
      .raddr(raddr[b]),
      .rdata(rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    px0 <= ix0[0];
    px1 <= ix1[0];
    py0 <= iy0[0];
    py1 <= iy1[0];
    pz0 <= iz0[0];
    pz1 <= iz1[0];
    fx_r <= fx;
    fy_r <= fy;
    fz_r <= fz;
  end

  always_comb begin
    logic [2:0] bk;
    for (int c = 0; c < 8; c++) begin
      bk = {c[2] ? pz1 : pz0, c[1] ? py1 : py0, c[0] ? px1 : px0};
      for (int ch = 0; ch < 3; ch++) begin
        corner[ch][c] = rdata[bk][ch*CHANNEL_BITS +: CHANNEL_BITS];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    vgts_blend u_blend (
      .clk,
      .corner(corner[ch]),
      .fx(fx_r),
      .fy(fy_r),
      .fz(fz_r),
      .result(res[ch])
    );
  end

  assign valid    = smp_vld[PIPE_LAT-1];
  assign sample_a = res[0];
  assign sample_b = res[1];
  assign sample_c = res[2];

endmodule

>>> src/vgts_checker.sv
// ----------------------------------------------------------------------------
// vgts_checker
// port-level timing checks on the voxel sampler, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vgts_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic operation,
  input logic valid
);
  import vgts_pkg::*;

  `VGTS_ASSERT(a_rst_clears, clk, rst |=> !valid)
  `VGTS_ASSERT_RST(a_valid_src, clk, rst, valid |-> $past(start && !busy && operation, PIPE_LAT))
  `VGTS_ASSERT_RST(a_sample_out, clk, rst, (start && !busy && operation) |-> ##PIPE_LAT valid)
  `VGTS_ASSERT_RST(a_write_quiet, clk, rst, (start && !busy && !operation) |-> ##PIPE_LAT !valid)

endmodule

bind voxel_grid_trilinear_sampler vgts_checker u_vgts_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the trilinear voxel sampler: the voxels around the grid corners are
// written, then directed and random write and sample items run under several
// grid sizes, each sample result compared with a typed value or a behavioral filter model
// ----------------------------------------------------------------------------
module tb_top;
  import vgts_pkg::*;

  localparam int STORE_N = MAX_EDGE * MAX_EDGE * MAX_EDGE;
  localparam int STALL_LIMIT = 1000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    op_t        op;
    logic [4:0] x, y, z;
    chan_t      a, b, c;
    coord_t     u, v, w;
  } voxel_item_t;

  typedef struct {
    voxel_item_t it;
    bit          known;
    chan_t       ea, eb, ec;
  } stim_row_t;

  typedef struct {
    chan_t a, b, c;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic operation = 1'b0;
  logic [4:0] voxel_x = '0, voxel_y = '0, voxel_z = '0;
  logic signed [15:0] value_a = '0, value_b = '0, value_c = '0;
  coord_t coord_u = '0, coord_v = '0, coord_w = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic valid;
  logic signed [15:0] sample_a, sample_b, sample_c;

  chan_t grid_a [STORE_N];
  chan_t grid_b [STORE_N];
  chan_t grid_c [STORE_N];
  bit written [STORE_N];
  logic [SIZE_W-1:0] grid_size [3];
  rgb_t pending_samples [$];
  int mismatch_count = 0;
  int samples_checked = 0;
  int writes_sent = 0;
  int stall_cycles = 0;
  bit idle_on = 1'b1;
  stim_row_t rows [$];

  voxel_grid_trilinear_sampler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
    .value_a(value_a), .value_b(value_b), .value_c(value_c),
    .coord_u(coord_u), .coord_v(coord_v), .coord_w(coord_w),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .valid(valid), .sample_a(sample_a), .sample_b(sample_b), .sample_c(sample_c)
  );

  always #5 clk = ~clk;

  function automatic void axis_split(input coord_t cd, input logic [SIZE_W-1:0] sz,
                                     output int i0, output int i1, output longint f);
    longint c, n, q, i;
    n = (sz == 0) ? 1 : (sz > MAX_EDGE) ? MAX_EDGE : sz;
    c = cd;
    if (c < 0) c = 0;
    if (c > 65536) c = 65536;
    q = c * n - 32768 + 65536;
    i = q / 65536 - 1;
    f = q % 65536;
    i0 = (i < 0) ? 0 : int'(i);
    i1 = (i + 1 > n - 1) ? int'(n - 1) : int'(i + 1);
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint f);
    return a + (((b - a) * f) >>> 16);
  endfunction

  function automatic longint voxel_at(input int ch, input int x, input int y, input int z);
    int ad;
    ad = (z * MAX_EDGE + y) * MAX_EDGE + x;
    return (ch == 0) ? grid_a[ad] : (ch == 1) ? grid_b[ad] : grid_c[ad];
  endfunction

  function automatic rgb_t filter_sample(input voxel_item_t it);
    int x0, x1, y0, y1, z0, z1;
    longint fx, fy, fz, p0, p1, q0, q1, r[3];
    rgb_t res;
    axis_split(it.u, grid_size[0], x0, x1, fx);
    axis_split(it.v, grid_size[1], y0, y1, fy);
    axis_split(it.w, grid_size[2], z0, z1, fz);
    for (int ch = 0; ch < 3; ch++) begin
      p0 = blend(voxel_at(ch, x0, y0, z0), voxel_at(ch, x1, y0, z0), fx);
      p1 = blend(voxel_at(ch, x0, y1, z0), voxel_at(ch, x1, y1, z0), fx);
      q0 = blend(voxel_at(ch, x0, y0, z1), voxel_at(ch, x1, y0, z1), fx);
      q1 = blend(voxel_at(ch, x0, y1, z1), voxel_at(ch, x1, y1, z1), fx);
      r[ch] = blend(blend(p0, p1, fy), blend(q0, q1, fy), fz);
    end
    res.a = chan_t'(r[0]);
    res.b = chan_t'(r[1]);
    res.c = chan_t'(r[2]);
    return res;
  endfunction

  // true when all eight voxels a sample item reads have been written
  function automatic bit corners_written(input voxel_item_t it);
    int x0, x1, y0, y1, z0, z1;
    longint f;
    int xs [2], ys [2], zs [2];
    bit ok;
    axis_split(it.u, grid_size[0], x0, x1, f);
    axis_split(it.v, grid_size[1], y0, y1, f);
    axis_split(it.w, grid_size[2], z0, z1, f);
    xs = '{x0, x1};
    ys = '{y0, y1};
    zs = '{z0, z1};
    ok = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (!written[(zs[k[2]] * MAX_EDGE + ys[k[1]]) * MAX_EDGE + xs[k[0]]]) ok = 1'b0;
    end
    return ok;
  endfunction

  // drive one item at the falling edge, hold until accepted
  task automatic send_item(input voxel_item_t it, input bit known, input rgb_t typed);
    int ad;
    start = 1'b1;
    operation = it.op;
    voxel_x = it.x; voxel_y = it.y; voxel_z = it.z;
    value_a = it.a; value_b = it.b; value_c = it.c;
    coord_u = it.u; coord_v = it.v; coord_w = it.w;
    do @(posedge clk); while (busy);
    if (it.op == OP_WRITE) begin
      ad = {it.z, it.y, it.x};
      grid_a[ad] = it.a;
      grid_b[ad] = it.b;
      grid_c[ad] = it.c;
      written[ad] = 1'b1;
      writes_sent++;
    end else begin
      pending_samples.push_back(known ? typed : filter_sample(it));
    end
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // write any voxel a sample item would read that is still unwritten
  task automatic cover_corners(input voxel_item_t it);
    int x0, x1, y0, y1, z0, z1;
    longint f;
    int xs [2], ys [2], zs [2];
    rgb_t none;
    none = '{default: '0};
    axis_split(it.u, grid_size[0], x0, x1, f);
    axis_split(it.v, grid_size[1], y0, y1, f);
    axis_split(it.w, grid_size[2], z0, z1, f);
    xs = '{x0, x1};
    ys = '{y0, y1};
    zs = '{z0, z1};
    for (int k = 0; k < 8; k++) begin
      if (!written[(zs[k[2]] * MAX_EDGE + ys[k[1]]) * MAX_EDGE + xs[k[0]]])
        send_item(make_item(OP_WRITE, xs[k[0]], ys[k[1]], zs[k[2]], $urandom, $urandom,
                            $urandom, 0, 0, 0), 1'b0, none);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [SIZE_W-1:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx != REG_NONE) grid_size[idx] = d;
  endtask

  function automatic voxel_item_t make_item(input op_t op, input int x, input int y,
                                            input int z, input int a, input int b,
                                            input int c, input int u, input int v,
                                            input int w);
    voxel_item_t it;
    it.op = op;
    it.x = 5'(x); it.y = 5'(y); it.z = 5'(z);
    it.a = chan_t'(a); it.b = chan_t'(b); it.c = chan_t'(c);
    it.u = coord_t'(u); it.v = coord_t'(v); it.w = coord_t'(w);
    return it;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0:       return coord_t'($urandom);
      1:       return coord_t'($urandom_range(0, 2047));
      2:       return coord_t'(65536 - $urandom_range(0, 2047));
      default: return coord_t'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic voxel_item_t rand_item();
    voxel_item_t it;
    if ($urandom_range(0, 9) < 3)
      return make_item(OP_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 31), $urandom, $urandom, $urandom, 0, 0, 0);
    for (int t = 0; t < 200; t++) begin
      it = make_item(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, rand_coord(), rand_coord(), rand_coord());
      if (corners_written(it)) return it;
    end
    return make_item(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, 0, 0, 0);
  endfunction

  function automatic stim_row_t row(input voxel_item_t it, input bit known,
                                    input int ea, input int eb, input int ec);
    stim_row_t r;
    r.it = it; r.known = known;
    r.ea = chan_t'(ea); r.eb = chan_t'(eb); r.ec = chan_t'(ec);
    return r;
  endfunction

  // result check
  always @(posedge clk) begin
    rgb_t e;
    if (valid) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result a=%0d b=%0d c=%0d", sample_a, sample_b, sample_c);
        mismatch_count++;
      end else begin
        e = pending_samples.pop_front();
        samples_checked++;
        if (sample_a !== e.a) begin
          $error("sample_a expected %0d actual %0d", e.a, sample_a);
          mismatch_count++;
        end
        if (sample_b !== e.b) begin
          $error("sample_b expected %0d actual %0d", e.b, sample_b);
          mismatch_count++;
        end
        if (sample_c !== e.c) begin
          $error("sample_c expected %0d actual %0d", e.c, sample_c);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rgb_t none;
    rgb_t typed;
    int sizes [8][3];
    int fill_pos [4];
    none = '{default: '0};
    grid_size = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
    sizes = '{'{1, 1, 1}, '{0, 63, 2}, '{2, 3, 4}, '{7, 32, 16}, '{33, 1, 5},
              '{$urandom, $urandom, $urandom}, '{31, 17, 9}, '{32, 32, 32}};
    fill_pos = '{0, 1, MAX_EDGE - 2, MAX_EDGE - 1};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // write the voxels next to every grid corner; samples only read written voxels
    foreach (fill_pos[k])
      foreach (fill_pos[j])
        foreach (fill_pos[i])
          send_item(make_item(OP_WRITE, fill_pos[i], fill_pos[j], fill_pos[k], $urandom,
                              $urandom, $urandom, 0, 0, 0), 1'b0, none);

    rows.push_back(row(make_item(OP_WRITE, 0, 0, 0, 32767, -32768, 0, 0, 0, 0), 0, 0, 0, 0));
    rows.push_back(row(make_item(OP_WRITE, 31, 31, 31, -32768, 32767, -1, 0, 0, 0),
                       0, 0, 0, 0));
    rows.push_back(row(make_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0, -131072, -131072, -131072),
                       1, 32767, -32768, 0));
    rows.push_back(row(make_item(OP_SAMPLE, 31, 31, 31, -1, -1, -1, 131071, 131071, 131071),
                       1, -32768, 32767, -1));
    rows.push_back(row(make_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 32767, -32768, 0));
    rows.push_back(row(make_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 65536, 65536, 65536),
                       1, -32768, 32767, -1));
    rows.push_back(row(make_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 32768, 32768, 32768), 0, 0, 0, 0));
    rows.push_back(row(make_item(OP_WRITE, 1, 0, 0, -32768, 32767, 256, 0, 0, 0), 0, 0, 0, 0));
    rows.push_back(row(make_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 3072, 0, 0), 0, 0, 0, 0));
    rows.push_back(row(make_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 2048, 1000, 65535), 0, 0, 0, 0));
    rows.push_back(row(make_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0, -1, 65537, 131071), 0, 0, 0, 0));
    rows.push_back(row(make_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 1, 65535, 40000), 0, 0, 0, 0));
    foreach (rows[i]) begin
      typed.a = rows[i].ea; typed.b = rows[i].eb; typed.c = rows[i].ec;
      if (rows[i].it.op == OP_SAMPLE) cover_corners(rows[i].it);
      send_item(rows[i].it, rows[i].known, typed);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph == 7) idle_on = 1'b0;
      write_reg(REG_SIZE_X, SIZE_W'(sizes[ph][0]));
      write_reg(REG_SIZE_Y, SIZE_W'(sizes[ph][1]));
      write_reg(REG_SIZE_Z, SIZE_W'(sizes[ph][2]));
      if (ph == 2) write_reg(REG_NONE, 6'h3f);
      repeat (80) send_item(rand_item(), 1'b0, none);
    end

    drain();
    $display("run: %0d voxel writes, %0d samples checked over 9 grid size settings",
             writes_sent, samples_checked);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
